### rtl/linear_interpolation_resampler_assert.svh
// ----------------------------------------------------------------------------
// linear interpolation resampler assertion macros
// concurrent assertion wrappers, compiled away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERPOLATION_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERPOLATION_RESAMPLER_ASSERT_SVH

`ifndef SYNTH
// property that holds in the same cycle
`define LIR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent that must hold in the cycle after the antecedent
`define LIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LIR_ASSERT(label, clk, rst_n, prop, msg)
`define LIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// shared types and constants of the linear interpolation resampler
// ----------------------------------------------------------------------------
package lir_pkg;

  // configuration register
  localparam int CFG_W = 20;
  localparam logic [CFG_W-1:0] RATIO_RESET = 20'd65536;
  localparam logic REG_RATIO_IDX = 1'b0;

  // results one input beat can cause
  localparam int MAX_RES = 8;
  localparam int CNT_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_MUL,
    ST_ADD,
    ST_TAIL,
    ST_LAST
  } lir_state_e;

endpackage

### rtl/linear_interpolation_resampler.sv
// ----------------------------------------------------------------------------
// linear_interpolation_resampler
// block-based linear interpolation sample rate converter with stream ports
// ----------------------------------------------------------------------------
// Samples of a block enter one beat at a time and leave resampled at the
// ratio held in rate_ratio (unsigned Q4.16, input rate over output rate,
// clamped to 0.25..12). After accept a beat passes through ST_PEND, then
// ST_MUL and ST_ADD for each interpolated output, at block end ST_TAIL for
// each repeated tail output, and last ST_LAST, waiting while the output
// side stalls; s_axis_tready is high only between beats. Interpolated
// outputs share the single multiplier in lir_interp, and the staging path
// takes at most one result per cycle.
// An output waits in a staging register until the next one is known so
// that run_end can be marked; tlast carries out_block_end.
module linear_interpolation_resampler
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: [SAMPLE_BITS-1:0] in_sample, rest zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tlast: in_block_end
  input  logic                 s_axis_tlast,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: [SAMPLE_BITS-1:0] out_sample, rest zero
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tlast: out_block_end
  output logic                 m_axis_tlast,
  // tuser: [0] run_end, [1] no_sample
  output logic [1:0]           m_axis_tuser,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int DW      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OFF_W   = FRAC_BITS + 5;
  localparam int RATIO_W = FRAC_BITS + 4;
  localparam int CW      = (CFG_W > RATIO_W) ? CFG_W : RATIO_W;
  localparam int ONE     = 2 ** FRAC_BITS;

  localparam logic [CW-1:0]    RATIO_LO = CW'(ONE / 4);
  localparam logic [CW-1:0]    RATIO_HI = CW'(12 * ONE);
  localparam logic [OFF_W-1:0] ONE_V    = OFF_W'(ONE);
  localparam logic [OFF_W-1:0] TWO_V    = OFF_W'(2 * ONE);

  lir_state_e state_q, state_d;

  logic [CFG_W-1:0]       ratio_cfg_q;
  logic [RATIO_W-1:0]     ratio_q, ratio_d;
  logic signed [SAMPLE_BITS-1:0] cur_q, cur_d;
  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic                   end_q, end_d;
  logic [OFF_W-1:0]       off_q, off_d;
  logic signed [SAMPLE_BITS-1:0] held_q, held_d;
  logic [OFF_W-1:0]       next_off_q, next_off_d;
  logic                   have_held_q, have_held_d;
  logic signed [SAMPLE_BITS-1:0] pend_val_q, pend_val_d;
  logic [OFF_W-1:0]       pend_end_q, pend_end_d;
  logic                   pend_valid_q, pend_valid_d;
  logic signed [SAMPLE_BITS-1:0] stg_val_q, stg_val_d;
  logic                   stg_nos_q, stg_nos_d;
  logic                   stg_valid_q, stg_valid_d;
  logic [CNT_W-1:0]       res_cnt_q, res_cnt_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;
  logic                   out_run_q, out_run_d;
  logic                   out_blk_q, out_blk_d;
  logic                   out_nos_q, out_nos_d;
  logic                   out_valid_q, out_valid_d;

  logic [CW-1:0]          cfg_ext;
  logic [CW-1:0]          ratio_clamp;
  logic [OFF_W-1:0]       sum_w;
  logic                   out_free;
  logic                   can_emit;
  logic                   mul_load;
  logic signed [SAMPLE_BITS-1:0] interp_val;
  logic                   cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RATIO_IDX);
  assign prdata = (paddr[2] == REG_RATIO_IDX) ? 32'(ratio_cfg_q) : 32'd0;

  assign cfg_ext     = CW'(ratio_cfg_q);
  assign ratio_clamp = (cfg_ext < RATIO_LO) ? RATIO_LO :
                       (cfg_ext > RATIO_HI) ? RATIO_HI : cfg_ext;

  // shared position adder
  assign sum_w    = off_q + OFF_W'(ratio_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign can_emit = !stg_valid_q || out_free;

  lir_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .load_i  (mul_load),
    .a_i     (prev_q),
    .b_i     (cur_q),
    .frac_i  (off_q[FRAC_BITS-1:0]),
    .value_o (interp_val)
  );

  always_comb begin
    logic                          emit;
    logic signed [SAMPLE_BITS-1:0] emit_val;
    logic                          emit_nos;
    logic                          finish;

    emit     = 1'b0;
    emit_val = '0;
    emit_nos = 1'b0;
    finish   = 1'b0;
    mul_load = 1'b0;
    s_axis_tready = 1'b0;

    state_d      = state_q;
    ratio_d      = ratio_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    end_d        = end_q;
    off_d        = off_q;
    held_d       = held_q;
    next_off_d   = next_off_q;
    have_held_d  = have_held_q;
    pend_val_d   = pend_val_q;
    pend_end_d   = pend_end_q;
    pend_valid_d = pend_valid_q;
    stg_val_d    = stg_val_q;
    stg_nos_d    = stg_nos_q;
    stg_valid_d  = stg_valid_q;
    res_cnt_d    = res_cnt_q;
    out_sample_d = out_sample_q;
    out_run_d    = out_run_q;
    out_blk_d    = out_blk_q;
    out_nos_d    = out_nos_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cur_d     = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
          end_d     = s_axis_tlast;
          ratio_d   = RATIO_W'(ratio_clamp);
          res_cnt_d = '0;
          // positions relative to the previous sample
          if (have_held_q) begin
            prev_d = held_q;
            off_d  = next_off_q;
          end else begin
            prev_d = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
            off_d  = next_off_q + ONE_V;
          end
          state_d = ST_PEND;
        end
      end
      ST_PEND: begin
        if (pend_valid_q && (pend_end_q <= ONE_V)) begin
          if (can_emit) begin
            emit         = 1'b1;
            emit_val     = pend_val_q;
            pend_valid_d = 1'b0;
            state_d      = ST_MUL;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (off_q < ONE_V) begin
          mul_load = 1'b1;
          state_d  = ST_ADD;
        end else begin
          state_d = end_q ? ST_TAIL : ST_LAST;
        end
      end
      ST_ADD: begin
        if (sum_w <= TWO_V) begin
          if (can_emit) begin
            emit     = 1'b1;
            emit_val = interp_val;
            off_d    = sum_w;
            state_d  = ST_MUL;
          end
        end else begin
          // value known now, existence only once the block length is
          pend_val_d   = interp_val;
          pend_end_d   = sum_w - ONE_V;
          pend_valid_d = 1'b1;
          off_d        = sum_w;
          state_d      = ST_MUL;
        end
      end
      ST_TAIL: begin
        if ((off_q < TWO_V) && (sum_w <= TWO_V) && (res_cnt_q < CNT_W'(MAX_RES))) begin
          if (can_emit) begin
            emit     = 1'b1;
            emit_val = cur_q;
            off_d    = sum_w;
          end
        end else begin
          if (res_cnt_q == '0) begin
            emit     = 1'b1;
            emit_nos = 1'b1;
          end
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!stg_valid_q || out_free) begin
          if (stg_valid_q) begin
            out_sample_d = stg_val_q;
            out_nos_d    = stg_nos_q;
            out_run_d    = 1'b1;
            out_blk_d    = end_q;
            out_valid_d  = 1'b1;
            stg_valid_d  = 1'b0;
          end
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // staged result moves out when a newer one arrives
    if (emit) begin
      if (stg_valid_q) begin
        out_sample_d = stg_val_q;
        out_nos_d    = stg_nos_q;
        out_run_d    = 1'b0;
        out_blk_d    = 1'b0;
        out_valid_d  = 1'b1;
      end
      stg_val_d   = emit_val;
      stg_nos_d   = emit_nos;
      stg_valid_d = 1'b1;
      res_cnt_d   = res_cnt_q + CNT_W'(1);
    end

    if (finish) begin
      if (end_q) begin
        held_d       = '0;
        next_off_d   = '0;
        have_held_d  = 1'b0;
        pend_val_d   = '0;
        pend_end_d   = '0;
        pend_valid_d = 1'b0;
      end else begin
        held_d      = cur_q;
        have_held_d = 1'b1;
        next_off_d  = off_q - ONE_V;
        if (pend_valid_q && (pend_end_q >= ONE_V)) begin
          pend_end_d = pend_end_q - ONE_V;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_cfg_q  <= RATIO_RESET;
      held_q       <= '0;
      next_off_q   <= '0;
      have_held_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      stg_valid_q  <= 1'b0;
      res_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        ratio_cfg_q <= pwdata[CFG_W-1:0];
      end
      held_q       <= held_d;
      next_off_q   <= next_off_d;
      have_held_q  <= have_held_d;
      pend_valid_q <= pend_valid_d;
      stg_valid_q  <= stg_valid_d;
      res_cnt_q    <= res_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q      <= ratio_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    end_q        <= end_d;
    off_q        <= off_d;
    pend_val_q   <= pend_val_d;
    pend_end_q   <= pend_end_d;
    stg_val_q    <= stg_val_d;
    stg_nos_q    <= stg_nos_d;
    out_sample_q <= out_sample_d;
    out_run_q    <= out_run_d;
    out_blk_q    <= out_blk_d;
    out_nos_q    <= out_nos_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DW'($unsigned(out_sample_q));
  assign m_axis_tlast  = out_blk_q;
  assign m_axis_tuser  = {out_nos_q, out_run_q};

`include "linear_interpolation_resampler_assert.svh"

  `LIR_ASSERT(a_ready_stage_empty, clk_i, rst_ni, s_axis_tready |-> !stg_valid_q, "stage busy")
  `LIR_ASSERT(a_blk_run_end, clk_i, rst_ni, (out_valid_q && out_blk_q) |-> out_run_q, "no run end")
  `LIR_ASSERT(a_nos_zero, clk_i, rst_ni, out_valid_q && out_nos_q |-> out_sample_q == '0, "bad data")
  `LIR_ASSERT_NEXT(a_start, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, state_q == ST_PEND, "idle")

endmodule

### rtl/lir_interp.sv
// ----------------------------------------------------------------------------
// lir_interp
// shared interpolation unit: registered (b - a) * frac, then round to
// nearest and saturate a + product to the sample width
// ----------------------------------------------------------------------------
module lir_interp #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] a_i,
  input  logic signed [SAMPLE_BITS-1:0] b_i,
  input  logic        [FRAC_BITS-1:0]   frac_i,
  output logic signed [SAMPLE_BITS-1:0] value_o
);

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int SW = SAMPLE_BITS + FRAC_BITS + 3;
  localparam int HALF = 2 ** (FRAC_BITS - 1);

  localparam logic signed [SW-1:0] SAT_HI =
    SW'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
  localparam logic signed [SW-1:0] SAT_LO =
    SW'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}));

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PW-1:0]          prod_d;
  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_BITS-1:0] a_q;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          quot;

  assign diff   = (SAMPLE_BITS+1)'(b_i) - (SAMPLE_BITS+1)'(a_i);
  assign frac_s = $signed({1'b0, frac_i});
  assign prod_d = PW'(diff) * PW'(frac_s);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  // arithmetic shift is floor division, ties round up
  assign sum  = (SW'(a_q) <<< FRAC_BITS) + SW'(prod_q) + SW'(HALF);
  assign quot = sum >>> FRAC_BITS;

  always_comb begin
    if (quot > SAT_HI) begin
      value_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quot < SAT_LO) begin
      value_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      value_o = quot[SAMPLE_BITS-1:0];
    end
  end

endmodule

### sim/linear_interpolation_resampler_tb.sv
// ----------------------------------------------------------------------------
// linear_interpolation_resampler_tb
// self-checking testbench for the linear interpolation resampler
// ----------------------------------------------------------------------------
// Blocks of signed samples are streamed in at a range of ratios that are set
// through the register port. A local predictor works out the resampled beats
// for every accepted input beat. A checker process compares each output beat
// field by field with the oldest predicted beat. Both stream sides idle at
// random, and one test holds the output off long enough to stall the input.
module linear_interpolation_resampler_tb
  import lir_pkg::*;
();

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
  localparam int ONE         = 1 << FRAC_W;
  localparam int HALF        = ONE >> 1;
  localparam int POS_LIMIT   = 2 * ONE;
  localparam int SMAX        = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SMIN        = -SMAX - 1;

  localparam logic [CFG_W-1:0] RATIO_ONE = CFG_W'(ONE);
  localparam logic [CFG_W-1:0] RATIO_MIN = CFG_W'(ONE / 4);
  localparam logic [CFG_W-1:0] RATIO_MAX = CFG_W'(12 * ONE);
  localparam logic [CFG_W-1:0] RATIO_TOP = {CFG_W{1'b1}};

  localparam logic [2:0] RATIO_ADDR  = 3'(4 * REG_RATIO_IDX);
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  localparam int RANDOM_BEATS = 340;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 50;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       run_end;
    logic                       block_end;
    logic                       no_sample;
  } resampled_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  logic [CFG_W-1:0]           ratio_reg;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic [20:0]                offset_q;
  bit                         prev_valid;
  logic signed [SAMPLE_W-1:0] defer_sample;
  logic [20:0]                defer_end;
  bit                         defer_valid;

  resampled_t pending_outputs[$];
  int         mismatches;
  int         beats_sent;
  bit         no_idle;
  bit         hold_req;

  linear_interpolation_resampler #(
    .SAMPLE_BITS(SAMPLE_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [15:0] in_sample
    .s_axis_tlast (s_axis_tlast),   // in_block_end
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [15:0] out_sample
    .m_axis_tlast (m_axis_tlast),   // out_block_end
    .m_axis_tuser (m_axis_tuser),   // [0] run_end, [1] no_sample
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("mismatch: %s", what);
    mismatches++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] a,
                                                      input logic signed [SAMPLE_W-1:0] b,
                                                      input logic [FRAC_W-1:0] frac);
    longint acc;
    acc = longint'(a) * ONE + (longint'(b) - longint'(a)) * longint'(frac) + HALF;
    // floor division rounds ties up for either sign
    acc = acc >>> FRAC_W;
    if (acc > SMAX) acc = SMAX;
    if (acc < SMIN) acc = SMIN;
    return acc[SAMPLE_W-1:0];
  endfunction

  task automatic clear_block_state();
    prev_sample  = '0;
    offset_q     = '0;
    prev_valid   = 1'b0;
    defer_sample = '0;
    defer_end    = '0;
    defer_valid  = 1'b0;
  endtask

  task automatic predict_resample(input logic signed [SAMPLE_W-1:0] cur, input logic last);
    int unsigned ratio;
    int unsigned off;
    int unsigned pos_end;
    int          n;
    int          i;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] value;
    logic signed [SAMPLE_W-1:0] vals[$];
    ratio = ratio_reg;
    if (ratio < RATIO_MIN) ratio = RATIO_MIN;
    if (ratio > RATIO_MAX) ratio = RATIO_MAX;
    // positions relative to the previous sample index
    if (prev_valid) begin
      prev = prev_sample;
      off  = offset_q;
    end else begin
      prev = cur;
      off  = offset_q + ONE;
    end
    if (defer_valid && defer_end + ONE <= POS_LIMIT) begin
      vals.push_back(defer_sample);
      defer_valid = 1'b0;
    end
    while (off < ONE) begin
      value   = lerp(prev, cur, off[FRAC_W-1:0]);
      pos_end = off + ratio;
      if (pos_end <= POS_LIMIT) begin
        vals.push_back(value);
      end else begin
        // existence only known once the next sample shows up
        defer_sample = value;
        defer_end    = 21'(pos_end - ONE);
        defer_valid  = 1'b1;
      end
      off = pos_end;
    end
    if (last) begin
      // tail outputs repeat the final sample
      while (off < 2 * ONE && off + ratio <= POS_LIMIT && vals.size() < MAX_RES) begin
        vals.push_back(cur);
        off += ratio;
      end
      clear_block_state();
    end else begin
      prev_sample = cur;
      prev_valid  = 1'b1;
      offset_q    = 21'(off - ONE);
      if (defer_valid && defer_end >= ONE) defer_end = defer_end - 21'(ONE);
    end
    n = vals.size();
    if (last && n == 0) begin
      pending_outputs.push_back('{sample: '0, run_end: 1'b1, block_end: 1'b1, no_sample: 1'b1});
    end
    for (i = 0; i < n; i++) begin
      pending_outputs.push_back('{sample: vals[i], run_end: i == n - 1,
                                  block_end: last && i == n - 1, no_sample: 1'b0});
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(sample);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_resample(sample, last);
    beats_sent++;
  endtask

  // all expected beats out, then let the sequencer settle
  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == RATIO_ADDR) ratio_reg = data[CFG_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check_ratio();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RATIO_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(ratio_reg))
      report_mismatch($sformatf("rate_ratio read %h, expected %h", prdata, ratio_reg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ratio(input logic [CFG_W-1:0] ratio);
    logic [31:0] data;
    data = $urandom();
    data[CFG_W-1:0] = ratio;
    apb_write(RATIO_ADDR, data);
    apb_check_ratio();
  endtask

  function automatic logic [CFG_W-1:0] pick_ratio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CFG_W'($urandom_range(RATIO_MIN, 3 * ONE));
    if (r < 70) return CFG_W'($urandom_range(3 * ONE, RATIO_MAX));
    if (r < 78) return CFG_W'($urandom_range(0, RATIO_MIN - 1));
    if (r < 86) return CFG_W'($urandom_range(RATIO_MAX + 1, RATIO_TOP));
    case ($urandom_range(0, 3))
      0:       return RATIO_MIN;
      1:       return RATIO_MAX;
      2:       return RATIO_ONE;
      default: return RATIO_TOP;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0:       return SAMPLE_W'(SMAX);
        1:       return SAMPLE_W'(SMIN);
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'($urandom());
  endfunction

  task automatic send_block(input int len);
    int i;
    for (i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic test_register_access();
    apb_check_ratio();
    apb_write(UNUSED_ADDR, $urandom());
    apb_check_ratio();
    set_ratio(RATIO_ONE);
  endtask

  task automatic test_pass_through();
    set_ratio(RATIO_ONE);
    send_sample(SAMPLE_W'(SMAX), 1'b0);
    send_sample(SAMPLE_W'(SMIN), 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd21845, 1'b0);
    send_sample(-16'sd21846, 1'b0);
    send_sample(16'sd12345, 1'b1);
    drain_outputs();
  endtask

  task automatic test_block_without_output();
    set_ratio(CFG_W'(2 * ONE));
    send_sample(-16'sd1, 1'b1);
    drain_outputs();
    // clamped to the top ratio, three samples give only a no_sample beat
    set_ratio(RATIO_TOP);
    send_sample(16'sd4660, 1'b0);
    send_sample(-16'sd4660, 1'b0);
    send_sample(SAMPLE_W'(SMAX), 1'b1);
    drain_outputs();
  endtask

  task automatic test_dropped_deferred();
    // second output ends past the block and is dropped
    set_ratio(CFG_W'(ONE + HALF));
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b1);
    drain_outputs();
  endtask

  task automatic test_lowest_ratio();
    // clamped up to a quarter step, full swing between neighbors
    set_ratio('0);
    send_sample(SAMPLE_W'(SMAX), 1'b0);
    send_sample(SAMPLE_W'(SMIN), 1'b0);
    send_sample(SAMPLE_W'(SMAX), 1'b1);
    drain_outputs();
    set_ratio(RATIO_MIN);
    send_sample(SAMPLE_W'(SMIN), 1'b0);
    send_sample(SAMPLE_W'(SMAX), 1'b1);
    drain_outputs();
  endtask

  task automatic test_random_blocks();
    int target;
    int r;
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      set_ratio(pick_ratio());
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 10) send_block(1);
        else if (r < 85) send_block($urandom_range(2, 12));
        else send_block($urandom_range(13, 40));
      end
      drain_outputs();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    set_ratio(RATIO_MIN);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    send_block(40);
    no_idle  = 1'b0;
    drain_outputs();
  endtask

  // receiver: random ready, occasional long stalls, one forced hold-off
  initial begin : output_sink
    int hold_cnt;
    hold_cnt = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (hold_cnt == 0 && !no_idle && $urandom_range(0, 99) == 0) begin
        hold_cnt = $urandom_range(10, 40);
      end
      if (hold_cnt > 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt--;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin : check_outputs
    resampled_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat, sample %0d",
                                  $signed(m_axis_tdata[SAMPLE_W-1:0])));
      end else begin
        want = pending_outputs.pop_front();
        if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample)
          report_mismatch($sformatf("out_sample %0d, expected %0d",
                                    $signed(m_axis_tdata[SAMPLE_W-1:0]), want.sample));
        if (m_axis_tuser[0] !== want.run_end)
          report_mismatch($sformatf("run_end %b, expected %b", m_axis_tuser[0], want.run_end));
        if (m_axis_tlast !== want.block_end)
          report_mismatch($sformatf("out_block_end %b, expected %b",
                                    m_axis_tlast, want.block_end));
        if (m_axis_tuser[1] !== want.no_sample)
          report_mismatch($sformatf("no_sample %b, expected %b",
                                    m_axis_tuser[1], want.no_sample));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("linear_interpolation_resampler_tb failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    beats_sent    = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    ratio_reg     = RATIO_RESET;
    clear_block_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_access();
    test_pass_through();
    test_block_without_output();
    test_dropped_deferred();
    test_lowest_ratio();
    test_random_blocks();
    test_output_backpressure();

    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("linear_interpolation_resampler_tb passed");
    end else begin
      $display("linear_interpolation_resampler_tb failed");
    end
    $finish;
  end

endmodule

### linear_interpolation_resampler.f
+incdir+rtl
rtl/lir_pkg.sv
rtl/lir_interp.sv
rtl/linear_interpolation_resampler.sv
sim/linear_interpolation_resampler_tb.sv
